### hw/rtl/rgb2yuv_pkg.sv
// Shared types and constants for the RGBA to YUV 4:2:0 converter.
// No dependencies; used by the controller, datapath and top level.
package rgb2yuv_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Size registers and the width used to compare against them
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;
  localparam int SIZE_W = 14;
  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;

  // BT.601 integer coefficients
  localparam logic [7:0] C_Y_R  = 8'd66;
  localparam logic [7:0] C_Y_G  = 8'd129;
  localparam logic [7:0] C_Y_B  = 8'd25;
  localparam logic [7:0] C_U_R  = 8'd38;
  localparam logic [7:0] C_U_G  = 8'd74;
  localparam logic [7:0] C_U_B  = 8'd112;
  localparam logic [7:0] C_V_R  = 8'd112;
  localparam logic [7:0] C_V_G  = 8'd94;
  localparam logic [7:0] C_V_B  = 8'd18;
  localparam logic [15:0] ROUND_HALF  = 16'd128;
  // rounding (128) plus the 128 offset moved above the shift (128 << 8)
  localparam logic [15:0] CHROMA_BIAS = 16'h8080;
  localparam logic [8:0]  LUMA_OFS    = 9'd16;
  localparam logic [7:0]  CHROMA_MID  = 8'd128;
  localparam logic [7:0]  PIX_MAX     = 8'hff;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take a pixel, form c*alpha, read the line stores
    logic div;     // divide the products by 255
    logic conv;    // form Y, U, V
    logic finish;  // filter, write back, load the result register
  } cmd_t;

endpackage

### hw/rtl/rgb2yuv_ctrl.sv
// Sequencing FSM for the RGBA to YUV 4:2:0 converter.
// Depends on rgb2yuv_pkg (cmd_t); drives the datapath commands.
module rgb2yuv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  input  logic               res_stall,
  output logic               pix_stall,
  output logic               res_valid,
  output rgb2yuv_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_CONV, S_FILT} state_t;

  state_t state;

  always_comb begin
    cmd.load   = pix_valid && !pix_stall;
    cmd.div    = (state == S_DIV);
    cmd.conv   = (state == S_CONV);
    cmd.finish = (state == S_FILT) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pix_stall <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state     <= S_DIV;
            pix_stall <= 1'b1;
          end
        end
        S_DIV:  state <= S_CONV;
        S_CONV: state <= S_FILT;
        S_FILT: begin
          if (cmd.finish) begin
            state     <= S_IDLE;
            pix_stall <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
      // result register: fill on finish, drain when taken
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/rgb2yuv_dp.sv
// Datapath of the RGBA to YUV 4:2:0 converter: size registers, color math,
// chroma filters, line stores and result register. Depends on rgb2yuv_pkg.
module rgb2yuv_dp #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rgb2yuv_pkg::cmd_t                   cmd,
  input  logic                                cfg_write,
  input  logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  input  logic [7:0]                          alpha,
  output logic [7:0]                          luma,
  output logic                                chroma_valid,
  output logic [7:0]                          cb,
  output logic [7:0]                          cr,
  output logic                                frame_end
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = CW - 1;
  localparam int DEPTH = 2 ** AW;
  localparam int SW    = rgb2yuv_pkg::SIZE_W;
  localparam logic [SW-1:0] MAX_W = SW'(MAX_WIDTH);
  localparam logic [SW-1:0] MAX_H = SW'(MAX_HEIGHT);

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [15:0] s;
    s = p + {8'h00, p[15:8]} + 16'd1;
    return s[15:8];
  endfunction

  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] v,
                                             input logic [SW-1:0] maxv);
    logic [SW-1:0] e;
    e = {v[SW-1:1], 1'b0};
    if (e < SW'(2)) e = SW'(2);
    if (e > maxv) e = maxv;
    return e;
  endfunction

  function automatic logic [15:0] cmul(input logic [7:0] c, input logic [7:0] x);
    return {8'h00, c} * {8'h00, x};
  endfunction

  // size registers
  logic [rgb2yuv_pkg::FW_W-1:0] frame_width;
  logic [rgb2yuv_pkg::FH_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rgb2yuv_pkg::FW_RESET;
      frame_height <= rgb2yuv_pkg::FH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rgb2yuv_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[rgb2yuv_pkg::FW_W-1:0];
        rgb2yuv_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[rgb2yuv_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] eff_w, eff_h;
  assign eff_w = eff_size(SW'(frame_width), MAX_W);
  assign eff_h = eff_size(SW'(frame_height), MAX_H);

  // position and left-neighbor state
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [7:0]    cb_recent0, cb_recent1, cr_recent0, cr_recent1;
  logic [AW:0]   fill;
  logic [AW-1:0] k;
  logic          last_col, last_row, col_odd, row_odd;

  assign k        = column_count[CW-1:1];
  assign col_odd  = column_count[0];
  assign row_odd  = row_count[0];
  assign last_col = ({{(SW-CW){1'b0}}, column_count} + SW'(1)) >= eff_w;
  assign last_row = ({{(SW-RW){1'b0}}, row_count} + SW'(1)) >= eff_h;

  // pipeline registers
  logic [15:0] prod_r, prod_g, prod_b;
  logic [7:0]  pr, pg, pb;
  logic [7:0]  y_q, u_q, v_q;
  logic [15:0] rd_above, rd_even;
  logic        above_ok;

  logic [15:0] y_sum, u_sum, v_sum;
  logic [8:0]  y_full;
  logic [7:0]  y_clamped;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      prod_r   <= cmul(red, alpha);
      prod_g   <= cmul(green, alpha);
      prod_b   <= cmul(blue, alpha);
      above_ok <= ({1'b0, k} < fill);
    end
    if (cmd.div) begin
      pr <= div255(prod_r);
      pg <= div255(prod_g);
      pb <= div255(prod_b);
    end
    if (cmd.conv) begin
      y_q <= y_clamped;
      u_q <= u_sum[15:8];
      v_q <= v_sum[15:8];
    end
  end

  always_comb begin
    y_sum = cmul(rgb2yuv_pkg::C_Y_R, pr) + cmul(rgb2yuv_pkg::C_Y_G, pg)
          + cmul(rgb2yuv_pkg::C_Y_B, pb) + rgb2yuv_pkg::ROUND_HALF;
    u_sum = cmul(rgb2yuv_pkg::C_U_B, pb) + rgb2yuv_pkg::CHROMA_BIAS
          - cmul(rgb2yuv_pkg::C_U_R, pr) - cmul(rgb2yuv_pkg::C_U_G, pg);
    v_sum = cmul(rgb2yuv_pkg::C_V_R, pr) + rgb2yuv_pkg::CHROMA_BIAS
          - cmul(rgb2yuv_pkg::C_V_G, pg) - cmul(rgb2yuv_pkg::C_V_B, pb);
    y_full    = {1'b0, y_sum[15:8]} + rgb2yuv_pkg::LUMA_OFS;
    y_clamped = (y_full > 9'(rgb2yuv_pkg::PIX_MAX)) ? rgb2yuv_pkg::PIX_MAX : y_full[7:0];
  end

  // horizontal then vertical 1-2-1 filters
  logic [7:0] lu, lv, hu, hv, tu, tv, cb_f, cr_f;
  logic [9:0] hsum_u, hsum_v, vsum_u, vsum_v;
  logic       top_pad, wr_above, wr_even;

  always_comb begin
    lu      = (column_count == CW'(1)) ? rgb2yuv_pkg::CHROMA_MID : cb_recent1;
    lv      = (column_count == CW'(1)) ? rgb2yuv_pkg::CHROMA_MID : cr_recent1;
    hsum_u  = {2'b00, lu} + {1'b0, cb_recent0, 1'b0} + {2'b00, u_q};
    hsum_v  = {2'b00, lv} + {1'b0, cr_recent0, 1'b0} + {2'b00, v_q};
    hu      = hsum_u[9:2];
    hv      = hsum_v[9:2];
    top_pad = (row_count == RW'(1)) || !above_ok;
    tu      = top_pad ? rgb2yuv_pkg::CHROMA_MID : rd_above[15:8];
    tv      = top_pad ? rgb2yuv_pkg::CHROMA_MID : rd_above[7:0];
    vsum_u  = {2'b00, tu} + {1'b0, rd_even[15:8], 1'b0} + {2'b00, hu};
    vsum_v  = {2'b00, tv} + {1'b0, rd_even[7:0], 1'b0} + {2'b00, hv};
    cb_f    = vsum_u[9:2];
    cr_f    = vsum_v[9:2];
    wr_above = cmd.finish && col_odd && row_odd;
    wr_even  = cmd.finish && col_odd && !row_odd;
  end

  // line stores: {cb, cr} per 2-pixel column pair
  logic [15:0] mem_above [DEPTH];
  logic [15:0] mem_even  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_above) mem_above[k] <= {hu, hv};
    if (cmd.load) rd_above <= mem_above[k];
  end

  always_ff @(posedge clk) begin
    if (wr_even) mem_even[k] <= {hu, hv};
    if (cmd.load) rd_even <= mem_even[k];
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      cb_recent0   <= rgb2yuv_pkg::CHROMA_MID;
      cb_recent1   <= rgb2yuv_pkg::CHROMA_MID;
      cr_recent0   <= rgb2yuv_pkg::CHROMA_MID;
      cr_recent1   <= rgb2yuv_pkg::CHROMA_MID;
      fill         <= '0;
    end else if (cmd.finish) begin
      cb_recent1 <= cb_recent0;
      cb_recent0 <= u_q;
      cr_recent1 <= cr_recent0;
      cr_recent0 <= v_q;
      if (wr_above && ({1'b0, k} >= fill)) fill <= {1'b0, k} + (AW+1)'(1);
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + RW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      luma         <= y_q;
      chroma_valid <= col_odd && row_odd;
      cb           <= (col_odd && row_odd) ? cb_f : 8'h00;
      cr           <= (col_odd && row_odd) ? cr_f : 8'h00;
      frame_end    <= last_col && last_row;
    end
  end

endmodule

### hw/rtl/rgba_to_yuv420_filtered_converter.sv
// Top level of the RGBA to YUV 4:2:0 converter with filtered chroma.
// Depends on rgb2yuv_pkg, rgb2yuv_ctrl and rgb2yuv_dp.
//
//   channel  handshake              payload
//   -------  ---------------------  -------------------------------------
//   pixel    pix_valid / pix_stall  red, green, blue, alpha
//   result   res_valid / res_stall  luma, chroma_valid, cb, cr, frame_end
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel passes four steps in rgb2yuv_ctrl: accept (products
// c*alpha, line store read), divide by 255, form Y/U/V, filter and write
// back; the next pixel is not accepted until the filter step is done.
// A finished beat sits in the result register; a stalled result holds the
// filter step until the register drains, and the next pixel waits with it.
// Synchronous reset returns the sequencer to idle, clears the position
// counters and the row-above fill count, and loads 640x480.
// cfg_ready is always high; write sizes only while no pixel is in flight.
module rgba_to_yuv420_filtered_converter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel channel
  input  logic                                pix_valid,
  output logic                                pix_stall,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  input  logic [7:0]                          alpha,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [7:0]                          luma,
  output logic                                chroma_valid,
  output logic [7:0]                          cb,
  output logic [7:0]                          cr,
  output logic                                frame_end,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rgb2yuv_pkg::cmd_t cmd;

  // size registers take a write in any cycle
  assign cfg_ready = 1'b1;

  rgb2yuv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .res_stall (res_stall),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .cmd       (cmd)
  );

  rgb2yuv_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .cb           (cb),
    .cr           (cr),
    .frame_end    (frame_end)
  );

endmodule

### hw/rtl/rgb2yuv_chk.sv
// Port-level checks for the RGBA to YUV 4:2:0 converter, bound to its top.
// Watches the pixel and result channels only; no package needed.
module rgb2yuv_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                pix_valid,
  input logic                                pix_stall,
  input logic [7:0]                          red,
  input logic [7:0]                          green,
  input logic [7:0]                          blue,
  input logic [7:0]                          alpha,
  input logic                                res_valid,
  input logic                                res_stall,
  input logic [7:0]                          luma,
  input logic                                chroma_valid,
  input logic [7:0]                          cb,
  input logic [7:0]                          cr,
  input logic                                frame_end
);

  // a taken pixel blocks the next one while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_stall |=> pix_stall)
    else $error("pixel channel open right after a beat");

  // a stalled pixel beat holds
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=>
      pix_valid && $stable(red) && $stable(green) && $stable(blue)
      && $stable(alpha))
    else $error("stalled pixel beat changed");

  // luma of any pixel stays inside the BT.601 studio range
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> luma >= 8'd16 && luma <= 8'd235)
    else $error("luma outside 16..235");

  // chroma is zero on beats that carry no 2x2 block
  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !chroma_valid |-> cb == 8'd0 && cr == 8'd0)
    else $error("chroma nonzero without chroma_valid");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=>
      res_valid && $stable(luma) && $stable(chroma_valid) && $stable(cb)
      && $stable(cr) && $stable(frame_end))
    else $error("stalled result beat changed");

endmodule

bind rgba_to_yuv420_filtered_converter rgb2yuv_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .pix_valid    (pix_valid),
  .pix_stall    (pix_stall),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .alpha        (alpha),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .luma         (luma),
  .chroma_valid (chroma_valid),
  .cb           (cb),
  .cr           (cr),
  .frame_end    (frame_end)
);
